// File: design/evag_pkg.sv
package evag_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int THRESH_W  = 16;
	localparam int LIMIT_W   = 7;
	localparam int LEN_W     = 13;
	localparam int POS_W     = 12;
	localparam int SQ_W      = 31;
	localparam int SUM_W     = 43;
	localparam int THSQ_W    = 32;
	localparam int PROD_W    = 44;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [LEN_W-1:0] MAX_FRAME = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH    = 2'd3;

	localparam logic [THRESH_W-1:0] START_THRESHOLD_RST = 16'd500;
	localparam logic [THRESH_W-1:0] STOP_THRESHOLD_RST  = 16'd300;
	localparam logic [LIMIT_W-1:0]  SILENCE_LIMIT_RST   = 7'd50;
	localparam logic [LEN_W-1:0]    FRAME_LENGTH_RST    = 13'd320;

	localparam logic [THSQ_W-1:0] START_SQ_RST   = 32'd250000;
	localparam logic [THSQ_W-1:0] STOP_SQ_RST    = 32'd90000;
	localparam logic [PROD_W-1:0] START_PROD_RST = 44'd80000000;
	localparam logic [PROD_W-1:0] STOP_PROD_RST  = 44'd28800000;

	typedef struct packed {
		logic [LEN_W-1:0]   eff_len;
		logic [LIMIT_W-1:0] silence_limit;
		logic [PROD_W-1:0]  start_prod;
		logic [PROD_W-1:0]  stop_prod;
	} cfg_t;

	typedef struct packed {
		logic             fire;
		logic [SUM_W-1:0] energy;
	} frame_t;

endpackage

// File: design/energy_voice_activity_gate.sv
// Energy based voice activity gate.
// Input channel: sample (signed 16 bit) with in_valid / in_ready. Each
// transfer adds the sample's square to the energy of the current frame.
// Output channel: keep_frame, utterance_end, voice_started with out_valid /
// out_ready. One result is given per frame, after its last sample; no other
// sample yields a result.
// Throughput: one sample per cycle while no stall holds the input (below).
// The square is registered at the transfer; accumulate and compare follow,
// and the result register holds the flags until out_ready takes them.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge
// (0 start threshold, 1 stop threshold, 2 silence limit, 3 frame length).
// Threshold writes reach the products via square and product registers,
// length writes via the product registers only. Reset: registers return to
// 500, 300, 50, 320; energy, position and silence count clear, gate listens.
// Stall: while a result waits, samples that do not end a frame are still
// taken; a frame-ending sample holds in the input register until the
// result is taken, and in_ready drops behind it.
module energy_voice_activity_gate (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [evag_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	output logic                                  keep_frame,
	output logic                                  utterance_end,
	output logic                                  voice_started,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic                                  cfg_wr_en,
	input  logic [evag_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [evag_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import evag_pkg::*;

	cfg_t   cfg;
	frame_t frame;
	logic   slot_free;

	evag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	evag_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.eff_len   (cfg.eff_len),
		.slot_free (slot_free),
		.frame     (frame)
	);

	evag_decide u_decide (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.frame         (frame),
		.slot_free     (slot_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.keep_frame    (keep_frame),
		.utterance_end (utterance_end),
		.voice_started (voice_started)
	);

endmodule

// File: design/evag_cfg.sv
module evag_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [evag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [evag_pkg::CFG_DATA_W-1:0]  cfg_data,
	output evag_pkg::cfg_t                   cfg
);
	import evag_pkg::*;

	logic [THRESH_W-1:0] start_q;
	logic [THRESH_W-1:0] stop_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [LEN_W-1:0]    length_q;
	logic [THSQ_W-1:0]   start_sq_q;
	logic [THSQ_W-1:0]   stop_sq_q;
	logic [PROD_W-1:0]   start_prod_q;
	logic [PROD_W-1:0]   stop_prod_q;
	logic [LEN_W-1:0]    eff_len;

	always_comb begin
		if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (length_q > MAX_FRAME) begin
			eff_len = MAX_FRAME;
		end else begin
			eff_len = length_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_THRESHOLD_RST;
			stop_q   <= STOP_THRESHOLD_RST;
			limit_q  <= SILENCE_LIMIT_RST;
			length_q <= FRAME_LENGTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_START_THRESHOLD: start_q  <= cfg_data[THRESH_W-1:0];
				CFG_STOP_THRESHOLD:  stop_q   <= cfg_data[THRESH_W-1:0];
				CFG_SILENCE_LIMIT:   limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_FRAME_LENGTH:    length_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// square, then scale by frame length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sq_q   <= START_SQ_RST;
			stop_sq_q    <= STOP_SQ_RST;
			start_prod_q <= START_PROD_RST;
			stop_prod_q  <= STOP_PROD_RST;
		end else begin
			start_sq_q   <= THSQ_W'(start_q) * THSQ_W'(start_q);
			stop_sq_q    <= THSQ_W'(stop_q) * THSQ_W'(stop_q);
			start_prod_q <= PROD_W'(start_sq_q) * PROD_W'(eff_len);
			stop_prod_q  <= PROD_W'(stop_sq_q) * PROD_W'(eff_len);
		end
	end

	assign cfg.eff_len       = eff_len;
	assign cfg.silence_limit = limit_q;
	assign cfg.start_prod    = start_prod_q;
	assign cfg.stop_prod     = stop_prod_q;

endmodule

// File: design/evag_accum.sv
module evag_accum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [evag_pkg::SAMPLE_W-1:0] sample,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [evag_pkg::LEN_W-1:0]      eff_len,
	input  logic                            slot_free,
	output evag_pkg::frame_t                frame
);
	import evag_pkg::*;

	logic [SAMPLE_W-1:0] raw;
	logic [SAMPLE_W-1:0] mag;
	logic [SQ_W-1:0]     sq;
	logic [SQ_W-1:0]     sq_s1;
	logic                valid_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [POS_W-1:0]    pos_q;
	logic [SUM_W-1:0]    sum_next;
	logic                last;
	logic                adv;
	logic                take;

	assign raw  = sample;
	assign mag  = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
	assign sq   = SQ_W'(mag) * SQ_W'(mag);

	assign sum_next = sum_q + SUM_W'(sq_s1);
	assign last     = (LEN_W'(pos_q) + LEN_W'(1)) >= eff_len;
	assign adv      = valid_s1 && (!last || slot_free);
	assign in_ready = !valid_s1 || adv;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1 <= sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			pos_q <= '0;
		end else if (adv) begin
			if (last) begin
				sum_q <= '0;
				pos_q <= '0;
			end else begin
				sum_q <= sum_next;
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	assign frame.fire   = adv && last;
	assign frame.energy = sum_next;

endmodule

// File: design/evag_decide.sv
module evag_decide (
	input  logic             clk,
	input  logic             arst_n,
	input  evag_pkg::cfg_t   cfg,
	input  evag_pkg::frame_t frame,
	output logic             slot_free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             keep_frame,
	output logic             utterance_end,
	output logic             voice_started
);
	import evag_pkg::*;

	logic               rec_q;
	logic [LIMIT_W-1:0] sil_q;
	logic               out_valid_q;
	logic               keep_q;
	logic               end_q;
	logic               start_q;

	logic               started;
	logic               rec_mid;
	logic [LIMIT_W-1:0] sil_base;
	logic [LIMIT_W:0]   sil_next;
	logic               quiet;
	logic               ended;
	logic               rec_d;
	logic [LIMIT_W-1:0] sil_d;

	always_comb begin
		started  = !rec_q && (PROD_W'(frame.energy) > cfg.start_prod);
		rec_mid  = rec_q || started;
		sil_base = started ? '0 : sil_q;
		quiet    = PROD_W'(frame.energy) < cfg.stop_prod;
		sil_next = (LIMIT_W+1)'(sil_base) + (LIMIT_W+1)'(1);
		ended    = 1'b0;
		rec_d    = rec_mid;
		sil_d    = sil_base;
		if (rec_mid) begin
			if (quiet) begin
				if (sil_next > (LIMIT_W+1)'(cfg.silence_limit)) begin
					ended = 1'b1;
					rec_d = 1'b0;
					sil_d = '0;
				end else begin
					sil_d = sil_next[LIMIT_W-1:0];
				end
			end else begin
				sil_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= 1'b0;
			sil_q <= '0;
		end else if (frame.fire) begin
			rec_q <= rec_d;
			sil_q <= sil_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.fire) begin
			keep_q  <= rec_mid;
			end_q   <= ended;
			start_q <= started;
		end
	end

	assign slot_free     = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign keep_frame    = keep_q;
	assign utterance_end = end_q;
	assign voice_started = start_q;

endmodule

// File: design/evag_check.sv
module evag_check (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic signed [evag_pkg::SAMPLE_W-1:0]  sample,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  keep_frame,
	input logic                                  utterance_end,
	input logic                                  voice_started,
	input logic                                  out_valid,
	input logic                                  out_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(keep_frame)
			&& $stable(utterance_end) && $stable(voice_started))
		else $error("result changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("sample changed while stalled");

	a_flags_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (utterance_end || voice_started) |-> keep_frame)
		else $error("start or end flagged on a frame not kept");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 2))
		else $error("result appeared with no sample behind it");

endmodule

bind energy_voice_activity_gate evag_check u_evag_check (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import evag_pkg::*;

	typedef struct packed {
		logic keep;
		logic ended;
		logic started;
	} gate_flags_t;

	typedef enum {
		LVL_LOUD, LVL_QUIET, LVL_AT_START, LVL_AT_STOP, LVL_MID, LVL_NOISE
	} frame_level_t;

	class gate_tracker;
		bit [THRESH_W-1:0] start_thr;
		bit [THRESH_W-1:0] stop_thr;
		bit [LIMIT_W-1:0]  limit;
		bit [LEN_W-1:0]    flen;
		bit [PROD_W-1:0]   start_prod;
		bit [PROD_W-1:0]   stop_prod;
		bit [SUM_W-1:0]    energy;
		int unsigned       pos;
		bit                recording;
		int unsigned       silent;
		gate_flags_t       expected_flags[$];
		int                failures;

		function new();
			start_thr = START_THRESHOLD_RST;
			stop_thr  = STOP_THRESHOLD_RST;
			limit     = SILENCE_LIMIT_RST;
			flen      = FRAME_LENGTH_RST;
			energy    = '0;
			pos       = 0;
			recording = 1'b0;
			silent    = 0;
			failures  = 0;
			form_products();
		endfunction

		function int unsigned eff_len();
			int unsigned n;
			n = flen;
			if (n == 0) n = 1;
			if (n > MAX_FRAME) n = MAX_FRAME;
			return n;
		endfunction

		function void form_products();
			longint unsigned n;
			n = eff_len();
			start_prod = PROD_W'(longint'(start_thr) * longint'(start_thr) * n);
			stop_prod  = PROD_W'(longint'(stop_thr) * longint'(stop_thr) * n);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_START_THRESHOLD: start_thr = data[THRESH_W-1:0];
				CFG_STOP_THRESHOLD:  stop_thr = data[THRESH_W-1:0];
				CFG_SILENCE_LIMIT:   limit = data[LIMIT_W-1:0];
				CFG_FRAME_LENGTH:    flen = data[LEN_W-1:0];
				default: return;
			endcase
			form_products();
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s);
			int          v;
			longint      mag;
			gate_flags_t res;
			v = s;
			mag = (v < 0) ? -v : v;
			energy += SUM_W'(mag * mag);
			if (pos + 1 < eff_len()) begin
				pos++;
				return;
			end
			res = '0;
			if (!recording && energy > start_prod) begin
				recording = 1'b1;
				silent = 0;
				res.started = 1'b1;
			end
			if (recording) begin
				res.keep = 1'b1;
				if (energy < stop_prod) begin
					if (silent + 1 > limit) begin
						res.ended = 1'b1;
						recording = 1'b0;
						silent = 0;
					end else begin
						silent++;
					end
				end else begin
					silent = 0;
				end
			end
			energy = '0;
			pos = 0;
			expected_flags.push_back(res);
		endfunction

		function void check_frame(logic keep, logic ended, logic started);
			gate_flags_t exp_f;
			if (expected_flags.size() == 0) begin
				$error("result with no frame end pending: keep_frame %0b utterance_end %0b voice_started %0b",
					keep, ended, started);
				failures++;
				return;
			end
			exp_f = expected_flags.pop_front();
			if (keep !== exp_f.keep) begin
				$error("keep_frame: expected %0b, got %0b", exp_f.keep, keep);
				failures++;
			end
			if (ended !== exp_f.ended) begin
				$error("utterance_end: expected %0b, got %0b", exp_f.ended, ended);
				failures++;
			end
			if (started !== exp_f.started) begin
				$error("voice_started: expected %0b, got %0b", exp_f.started, started);
				failures++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic signed [SAMPLE_W-1:0]    sample = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          keep_frame;
	logic                          utterance_end;
	logic                          voice_started;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;

	gate_tracker tracker = new();
	int          in_idle_pct = 0;
	int          out_stall_pct = 0;
	int          n_sent = 0;

	energy_voice_activity_gate u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.keep_frame    (keep_frame),
		.utterance_end (utterance_end),
		.voice_started (voice_started),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_frame(keep_frame, utterance_end, voice_started);
	end

	task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		sample = s;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.note_sample(s);
		n_sent++;
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.expected_flags.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.write_reg(idx, data);
	endtask

	task automatic set_gate(int unsigned start, int unsigned stop, int unsigned limit,
			int unsigned flen);
		quiesce();
		write_reg(CFG_START_THRESHOLD, CFG_DATA_W'(start));
		write_reg(CFG_STOP_THRESHOLD, CFG_DATA_W'(stop));
		// upper bits beyond the register width are junk and must be dropped
		write_reg(CFG_SILENCE_LIMIT, {9'($urandom()), LIMIT_W'(limit)});
		write_reg(CFG_FRAME_LENGTH, {3'($urandom()), LEN_W'(flen)});
		repeat (4) @(negedge clk);
	endtask

	function automatic int unsigned clip_mag(int unsigned m);
		return (m > 32768) ? 32768 : m;
	endfunction

	function automatic int unsigned pick_level(frame_level_t kind);
		int unsigned st, sp, lo, hi;
		st = clip_mag(tracker.start_thr);
		sp = clip_mag(tracker.stop_thr);
		case (kind)
			LVL_LOUD:     return $urandom_range(32768, clip_mag(st + 1));
			LVL_QUIET:    return (sp == 0) ? 0 : $urandom_range(sp - 1, 0);
			LVL_AT_START: return st;
			LVL_AT_STOP:  return sp;
			default: begin
				lo = (st < sp) ? st : sp;
				hi = (st < sp) ? sp : st;
				return $urandom_range(hi, lo);
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] signed_sample(int unsigned m);
		if (m >= 32768)
			return 16'h8000;
		if ($urandom_range(1))
			return SAMPLE_W'(-int'(m));
		return SAMPLE_W'(m);
	endfunction

	task automatic send_frame(frame_level_t kind);
		int unsigned n, lvl;
		n = tracker.eff_len();
		lvl = pick_level(kind);
		repeat (n) begin
			if (kind == LVL_NOISE)
				send_sample(SAMPLE_W'($urandom()));
			else
				send_sample(signed_sample(lvl));
		end
	endtask

	task automatic send_utterance();
		int unsigned quiet_n;
		send_frame(LVL_LOUD);
		repeat ($urandom_range(3)) send_frame(frame_level_t'($urandom_range(4)));
		if ($urandom_range(9) == 0)
			quiet_n = $urandom_range(tracker.limit);
		else
			quiet_n = tracker.limit + 1;
		repeat (quiet_n) send_frame(LVL_QUIET);
	endtask

	task automatic run_phase(int idle, int stall, int budget);
		int first;
		in_idle_pct = idle;
		out_stall_pct = stall;
		first = n_sent;
		while (n_sent - first < budget) begin
			if ($urandom_range(3) == 0)
				send_frame(frame_level_t'($urandom_range(5)));
			else
				send_utterance();
		end
		// leave a partial frame so the next length applies mid-frame
		repeat ($urandom_range(tracker.eff_len() - 1)) send_sample(SAMPLE_W'($urandom()));
	endtask

	initial begin
		#2000000;
		$display("energy_voice_activity_gate test failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_gate(100, 200, 0, 0);
		send_sample(16'sd0);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd150);
		send_sample(16'sd150);
		send_sample(16'sd100);
		send_sample(16'sd101);
		send_sample(-16'sd1);
		send_sample(16'shAAAA);
		set_gate(100, 200, 5, 1);
		send_sample(16'sd150);
		send_sample(16'sd150);
		set_gate(100, 200, 1, 1);
		send_sample(-16'sd150);
		set_gate(100, 200, 0, 4);
		send_sample(16'sd0);
		send_sample(16'sd0);
		set_gate(100, 200, 0, 2);
		send_sample(16'sd0);
		send_sample(16'sh5555);

		set_gate(1000, 600, 3, 1);
		run_phase(0, 0, 80);
		set_gate(2000, 4000, 0, 3);
		run_phase(82, 0, 90);
		set_gate(0, 0, 1, 2);
		run_phase(0, 82, 60);
		set_gate(32767, 65535, 127, 1);
		run_phase(29, 29, 40);
		set_gate(300, 200, 2, 0);
		run_phase(0, 82, 60);
		set_gate(16000, 20000, 0, 8191);
		in_idle_pct = 0;
		out_stall_pct = 0;
		repeat (10) send_sample(signed_sample(pick_level(LVL_LOUD)));
		set_gate(5000, 5000, 5, 7);
		run_phase(82, 0, 80);
		set_gate(500, 300, 4, 4);
		run_phase(29, 29, 60);

		quiesce();
		if (tracker.failures == 0)
			$display("energy_voice_activity_gate test passed");
		else
			$display("energy_voice_activity_gate test failed");
		$finish;
	end

endmodule
